// ===== rtl/kmsd_pkg.sv =====
// Shared types and constants for the key matrix scanner with debounce.
// No dependencies; used by every other file of the block.
package kmsd_pkg;

  localparam int ROW_W     = 3;  // width of the row fields
  localparam int CNT_W     = 5;  // width of the debounce counter and thresholds
  localparam int PHASE_W   = 3;  // width of the per-key phase code
  localparam int IN_COLS   = 4;  // columns carried by the column_levels field
  localparam int CFG_IDX_W = 1;  // width of the register index

  // Per-key debounce phase codes. Codes above PH_UP are treated as unknown.
  localparam logic [PHASE_W-1:0] PH_UNKNOWN   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_DOWN = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DOWN      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT_UP   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_UP        = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 1'd1;

  localparam logic [CNT_W-1:0] PRESS_THRESHOLD_RESET   = 5'd2;
  localparam logic [CNT_W-1:0] RELEASE_THRESHOLD_RESET = 5'd4;

  // Event reported by one debounce lane for the key it evaluated.
  typedef struct packed {
    logic pressed;
    logic released;
  } lane_event_t;

  // One result item as held in the output buffer.
  typedef struct packed {
    logic [ROW_W-1:0]   scanned_row;
    logic [ROW_W-1:0]   next_row;
    logic [IN_COLS-1:0] press_mask;
    logic [IN_COLS-1:0] release_mask;
  } result_t;

endpackage

// ===== rtl/kmsd_lane.sv =====
// One column lane: debounce state of every key in a single matrix column.
// Depends on kmsd_pkg for phase codes, widths and the lane event type.
module kmsd_lane #(
  parameter int NUM_ROWS = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [kmsd_pkg::ROW_W-1:0] row_sel,
  input  logic                       sample_down,
  input  logic [kmsd_pkg::CNT_W-1:0] press_threshold,
  input  logic [kmsd_pkg::CNT_W-1:0] release_threshold,
  output kmsd_pkg::lane_event_t      lane_event
);

  localparam int ROW_IDX_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  logic [kmsd_pkg::PHASE_W-1:0] phase [NUM_ROWS];
  logic [kmsd_pkg::CNT_W-1:0]   count [NUM_ROWS];

  logic [ROW_IDX_W-1:0]         idx;
  logic [kmsd_pkg::PHASE_W-1:0] phase_cur;
  logic [kmsd_pkg::CNT_W-1:0]   count_cur;
  logic [kmsd_pkg::PHASE_W-1:0] phase_next;
  logic [kmsd_pkg::CNT_W-1:0]   count_next;

  assign idx       = row_sel[ROW_IDX_W-1:0];
  assign phase_cur = phase[idx];
  assign count_cur = count[idx];

  always_comb begin
    phase_next          = phase_cur;
    count_next          = count_cur;
    lane_event.pressed  = 1'b0;
    lane_event.released = 1'b0;
    unique case (phase_cur)
      kmsd_pkg::PH_WAIT_DOWN: begin
        if (!sample_down) begin
          phase_next = kmsd_pkg::PH_UP;
          count_next = '0;
        end else if (count_cur >= press_threshold) begin
          phase_next         = kmsd_pkg::PH_DOWN;
          count_next         = '0;
          lane_event.pressed = 1'b1;
        end else begin
          count_next = count_cur + 1'b1;
        end
      end
      kmsd_pkg::PH_DOWN: begin
        if (!sample_down) begin
          phase_next = kmsd_pkg::PH_WAIT_UP;
          count_next = '0;
        end
      end
      kmsd_pkg::PH_WAIT_UP: begin
        if (sample_down) begin
          phase_next = kmsd_pkg::PH_DOWN;
          count_next = '0;
        end else if (count_cur >= release_threshold) begin
          phase_next          = kmsd_pkg::PH_UP;
          count_next          = '0;
          lane_event.released = 1'b1;
        end else begin
          count_next = count_cur + 1'b1;
        end
      end
      kmsd_pkg::PH_UP: begin
        if (sample_down) begin
          phase_next = kmsd_pkg::PH_WAIT_DOWN;
          count_next = '0;
        end
      end
      default: begin
        // Unknown, and the unused codes: settle at once without an event.
        phase_next = sample_down ? kmsd_pkg::PH_DOWN : kmsd_pkg::PH_UP;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        phase[r] <= kmsd_pkg::PH_UNKNOWN;
        count[r] <= '0;
      end
    end else if (step) begin
      phase[idx] <= phase_next;
      count[idx] <= count_next;
    end
  end

endmodule

// ===== rtl/kmsd_out_buf.sv =====
// Two-entry output buffer that parts the input side from a stalled receiver.
// Depends on kmsd_pkg for the result item type.
module kmsd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kmsd_pkg::result_t push_data,
  output logic              can_push,
  input  logic              pop,
  output logic              head_valid,
  output kmsd_pkg::result_t head_data
);

  logic [1:0]        fill;
  kmsd_pkg::result_t entry0;
  kmsd_pkg::result_t entry1;

  assign can_push   = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_data  = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (fill == 2'd1) begin
        entry0 <= push_data;
      end else begin
        entry0 <= entry1;
        entry1 <= push_data;
      end
    end else if (pop) begin
      entry0 <= entry1;
    end else if (push) begin
      if (fill == 2'd0) begin
        entry0 <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end
  end

endmodule

// ===== rtl/key_matrix_scan_debounce.sv =====
// Top level of the key matrix scanner with per-key debounce.
// Depends on kmsd_pkg, kmsd_lane and kmsd_out_buf.
//
// Usage: each transfer on the input channel (in_valid/in_ready) is one scan
// tick and carries the active-low column levels of the row that the block
// selected on the previous tick. One debounce lane per column evaluates its
// key of that row in the same cycle, and the merged result (row scanned, row
// selected next, press and release masks) goes to the output channel
// (out_valid/out_ready).
// One tick is taken per cycle while in_ready is high: the lanes hold their
// keys' state in small per-row register files read at the current row, so the
// next tick may follow at once. Each result is registered in the output
// buffer and presented once the results ahead of it have been taken.
// A two-entry output buffer keeps input transfers flowing while a result
// waits; only when both entries are held by a stalled receiver does in_ready
// fall, and it rises again the cycle after a result transfer.
// Reset (synchronous, rst high) sets the row to zero, every key to the
// unknown phase with a cleared count, the thresholds to 2 and 4, and empties
// the buffer. The user writes the thresholds (cfg_we/cfg_index/cfg_data)
// only while idle; the block does not enforce it. Unused indexes are ignored.
module key_matrix_scan_debounce #(
  parameter int NUM_ROWS = 7,
  parameter int NUM_COLS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kmsd_pkg::IN_COLS-1:0]        column_levels,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kmsd_pkg::ROW_W-1:0]          scanned_row,
  output logic [kmsd_pkg::ROW_W-1:0]          next_row,
  output logic [kmsd_pkg::IN_COLS-1:0]        press_mask,
  output logic [kmsd_pkg::IN_COLS-1:0]        release_mask,
  input  logic                                cfg_we,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kmsd_pkg::CNT_W-1:0]          cfg_data
);

  localparam logic [kmsd_pkg::ROW_W-1:0] LAST_ROW = kmsd_pkg::ROW_W'(NUM_ROWS - 1);

  logic [kmsd_pkg::CNT_W-1:0] press_threshold;
  logic [kmsd_pkg::CNT_W-1:0] release_threshold;
  logic [kmsd_pkg::ROW_W-1:0] current_row;
  logic [kmsd_pkg::ROW_W-1:0] current_row_next;

  logic                  step;
  kmsd_pkg::lane_event_t lane_events [NUM_COLS];
  logic [kmsd_pkg::IN_COLS-1:0] press_bits;
  logic [kmsd_pkg::IN_COLS-1:0] release_bits;
  kmsd_pkg::result_t     result;
  kmsd_pkg::result_t     head;

  assign step = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold   <= kmsd_pkg::PRESS_THRESHOLD_RESET;
      release_threshold <= kmsd_pkg::RELEASE_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmsd_pkg::REG_PRESS_THRESHOLD:   press_threshold   <= cfg_data;
        kmsd_pkg::REG_RELEASE_THRESHOLD: release_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row sequencing: advance on every tick and wrap after the last row.
  assign current_row_next = (current_row == LAST_ROW) ? '0 : current_row + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
    end else if (step) begin
      current_row <= current_row_next;
    end
  end

  // One debounce lane per column. A column with no bit in the input field is
  // sampled as open; its events do not fit the masks and are dropped below.
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
    logic sample_down;
    if (c < kmsd_pkg::IN_COLS) begin : g_in
      assign sample_down = ~column_levels[c];
    end else begin : g_open
      assign sample_down = 1'b0;
    end

    kmsd_lane #(
      .NUM_ROWS (NUM_ROWS)
    ) u_lane (
      .clk               (clk),
      .rst               (rst),
      .step              (step),
      .row_sel           (current_row),
      .sample_down       (sample_down),
      .press_threshold   (press_threshold),
      .release_threshold (release_threshold),
      .lane_event        (lane_events[c])
    );
  end

  // Merge the lane events into the two masks.
  for (genvar c = 0; c < kmsd_pkg::IN_COLS; c++) begin : g_merge
    if (c < NUM_COLS) begin : g_used
      assign press_bits[c]   = lane_events[c].pressed;
      assign release_bits[c] = lane_events[c].released;
    end else begin : g_unused
      assign press_bits[c]   = 1'b0;
      assign release_bits[c] = 1'b0;
    end
  end

  assign result.scanned_row  = current_row;
  assign result.next_row     = current_row_next;
  assign result.press_mask   = press_bits;
  assign result.release_mask = release_bits;

  kmsd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (result),
    .can_push   (in_ready),
    .pop        (out_valid && out_ready),
    .head_valid (out_valid),
    .head_data  (head)
  );

  assign scanned_row  = head.scanned_row;
  assign next_row     = head.next_row;
  assign press_mask   = head.press_mask;
  assign release_mask = head.release_mask;

  // An empty buffer must always take the next tick.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output buffer is empty");

  // A tick taken into an empty buffer is presented in the next cycle.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (step && !out_valid) |=> out_valid)
    else $error("result not presented one cycle after its tick");

  // A key cannot be confirmed down and up on the same tick.
  a_masks_disjoint : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_mask & release_mask) == '0))
    else $error("press and release reported for the same key");

  // The reported rows stay in range and the next row follows the scanned one.
  a_row_sequence : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((scanned_row <= LAST_ROW) &&
                   (next_row == ((scanned_row == LAST_ROW) ? '0 : scanned_row + 1'b1))))
    else $error("row sequence out of order");

endmodule

// ===== dv/key_matrix_scan_debounce_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the key matrix scanner with per-key debounce.
// Depends on kmsd_pkg and key_matrix_scan_debounce, which needs kmsd_lane and kmsd_out_buf.
module key_matrix_scan_debounce_test;
  import kmsd_pkg::*;

  localparam int NUM_ROWS     = 7;
  localparam int NUM_COLS     = 4;
  localparam int NUM_KEYS     = NUM_ROWS * NUM_COLS;
  // Cycles without any transfer on either channel before the run is abandoned.
  // The longest legitimate quiet stretch is a long idle gap from pick_gap plus
  // a threshold write, so this leaves a wide margin.
  localparam int IDLE_LIMIT   = 2000;
  localparam int REPORT_LIMIT = 10;

  // Every input of the block starts at a known value.
  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 in_valid      = 1'b0;
  logic [IN_COLS-1:0]   column_levels = '0;
  logic                 out_ready     = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_PRESS_THRESHOLD;
  logic [CNT_W-1:0]     cfg_data      = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic [ROW_W-1:0]     scanned_row;
  logic [ROW_W-1:0]     next_row;
  logic [IN_COLS-1:0]   press_mask;
  logic [IN_COLS-1:0]   release_mask;

  key_matrix_scan_debounce #(
    .NUM_ROWS(NUM_ROWS),
    .NUM_COLS(NUM_COLS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .column_levels(column_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scanned_row  (scanned_row),
    .next_row     (next_row),
    .press_mask   (press_mask),
    .release_mask (release_mask),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scanner predictor: its own copy of the row pointer, of every key's debounce
  // phase and counter, and of the two thresholds. It is advanced once for each
  // input transfer, in transfer order.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]   model_row;
  logic [PHASE_W-1:0] model_phase [NUM_KEYS];
  logic [CNT_W-1:0]   model_count [NUM_KEYS];
  logic [CNT_W-1:0]   model_press_thr;
  logic [CNT_W-1:0]   model_release_thr;

  // Scan results still owed by the block, oldest first.
  result_t expected_scans [$];

  int  fail_count = 0;
  bit  idle_off   = 1'b0;   // when set, neither side inserts idle cycles
  int  stim_row   = 0;      // row that the next generated tick will hit
  int  stall_left = 0;
  int  rx_gap;

  // Stimulus plan per key: the level the key is meant to hold and for how many
  // more visits, plus the visits since its last change (bounce window).
  bit plan_down [NUM_KEYS];
  int plan_hold [NUM_KEYS];
  int plan_age  [NUM_KEYS];

  // One key's debounce machine for one sample. A press is confirmed only once
  // the count has already reached the threshold while the key is still down,
  // and likewise for a release; any disagreeing sample drops the key back to
  // its stable phase. An unknown phase settles at once without an event.
  function automatic lane_event_t debounce_key(int k, logic down);
    logic [PHASE_W-1:0] ph;
    logic [CNT_W-1:0]   n;
    lane_event_t        ev;
    ph = model_phase[k];
    n  = model_count[k];
    ev = '0;
    case (ph)
      PH_WAIT_DOWN: begin
        if (!down) begin
          ph = PH_UP;
          n  = '0;
        end else if (n >= model_press_thr) begin
          ph = PH_DOWN;
          n  = '0;
          ev.pressed = 1'b1;
        end else begin
          n = n + 1'b1;
        end
      end
      PH_DOWN: begin
        if (!down) begin
          ph = PH_WAIT_UP;
          n  = '0;
        end
      end
      PH_WAIT_UP: begin
        if (down) begin
          ph = PH_DOWN;
          n  = '0;
        end else if (n >= model_release_thr) begin
          ph = PH_UP;
          n  = '0;
          ev.released = 1'b1;
        end else begin
          n = n + 1'b1;
        end
      end
      PH_UP: begin
        if (down) begin
          ph = PH_WAIT_DOWN;
          n  = '0;
        end
      end
      default: begin
        ph = down ? PH_DOWN : PH_UP;
        n  = '0;
      end
    endcase
    model_phase[k] = ph;
    model_count[k] = n;
    return ev;
  endfunction

  // Evaluates the four keys of the current row for one tick (a low column bit
  // means the switch is closed) and moves the row pointer on, wrapping after
  // the last row.
  function automatic result_t scan_row_keys(logic [IN_COLS-1:0] levels);
    result_t     res;
    lane_event_t ev;
    int          k;
    res = '0;
    res.scanned_row = model_row;
    for (int c = 0; c < NUM_COLS; c++) begin
      k  = model_row + NUM_ROWS * c;
      ev = debounce_key(k, !levels[c]);
      res.press_mask[c]   = ev.pressed;
      res.release_mask[c] = ev.released;
    end
    model_row = (model_row == NUM_ROWS - 1) ? '0 : model_row + 1'b1;
    res.next_row = model_row;
    return res;
  endfunction

  // Idle gap length shared by both sides: mostly none, often a short one,
  // occasionally a long one.
  function automatic int pick_gap();
    int r;
    if (idle_off)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // How many further visits a key holds a new level. Most holds are just long
  // enough, or a little more than long enough, for the debounce to confirm;
  // some are far too short, which gives broken sequences.
  function automatic int pick_hold(int thr);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2)
      return $urandom_range(0, 1);
    if (r < 9)
      return thr + $urandom_range(1, 6);
    return thr + $urandom_range(7, 20);
  endfunction

  // Column levels for the row that the next tick scans. Each key follows its
  // plan, with contact bounce in the first two visits after a change, and now
  // and then a whole tick is random noise.
  function automatic logic [IN_COLS-1:0] gen_levels();
    logic [IN_COLS-1:0] levels;
    logic               down;
    int                 k;
    if ($urandom_range(0, 39) == 0) begin
      levels = IN_COLS'($urandom_range(0, 15));
      return levels;
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      k = stim_row + NUM_ROWS * c;
      if (plan_hold[k] == 0) begin
        plan_down[k] = !plan_down[k];
        plan_age[k]  = 0;
        plan_hold[k] = pick_hold(int'(plan_down[k] ? model_press_thr : model_release_thr));
      end else begin
        plan_hold[k]--;
      end
      down = plan_down[k];
      if (plan_age[k] < 2 && $urandom_range(0, 2) == 0)
        down = !down;
      plan_age[k]++;
      levels[c] = !down;
    end
    return levels;
  endfunction

  // Column levels that the first tick on each row uses to settle its keys;
  // between them every column bit is seen both open and closed.
  function automatic logic [IN_COLS-1:0] settle_levels(int r);
    case (r)
      0:       return 4'hF;
      1:       return 4'h0;
      2:       return 4'h5;
      3:       return 4'hA;
      4:       return 4'h3;
      5:       return 4'hC;
      default: return 4'h9;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid is raised after an optional idle gap and then held with
  // the payload steady until the transfer. It is only lowered when a gap is
  // about to start, so a back-to-back tick never sees valid drop and rise in
  // the same time step. The expectation is formed at the transfer edge.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [IN_COLS-1:0] levels);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    column_levels <= levels;
    do @(posedge clk); while (!in_ready);
    expected_scans.push_back(scan_row_keys(levels));
    stim_row = (stim_row == NUM_ROWS - 1) ? 0 : stim_row + 1;
  endtask

  // Stops sending and waits until every owed result has been taken, then lets
  // the block settle.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes both thresholds, one per cycle; only called while the block is idle.
  task automatic set_thresholds(input logic [CNT_W-1:0] press_thr,
                                input logic [CNT_W-1:0] release_thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PRESS_THRESHOLD;
    cfg_data  <= press_thr;
    @(posedge clk);
    cfg_index <= REG_RELEASE_THRESHOLD;
    cfg_data  <= release_thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    model_press_thr   = press_thr;
    model_release_thr = release_thr;
  endtask

  // Planned key traffic under one pair of thresholds.
  task automatic run_debounce_traffic(input int n_items,
                                      input logic [CNT_W-1:0] press_thr,
                                      input logic [CNT_W-1:0] release_thr,
                                      input bit quiet);
    wait_until_idle();
    set_thresholds(press_thr, release_thr);
    idle_off = quiet;
    repeat (n_items) send_tick(gen_levels());
    idle_off = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // First visit to every row straight after reset, at the reset thresholds:
  // each key leaves the unknown phase at once, so no event may be reported.
  task automatic test_settle_from_unknown();
    for (int r = 0; r < NUM_ROWS; r++)
      send_tick(settle_levels(r));
  endtask

  // With both thresholds at zero a change is confirmed on the second agreeing
  // visit. Every key is inverted once; then rows 0 to 3 keep the new level,
  // which confirms presses and releases, while rows 4 to 6 bounce back to
  // their settled level, which must cancel the change without an event.
  task automatic test_zero_thresholds();
    wait_until_idle();
    set_thresholds('0, '0);
    for (int r = 0; r < NUM_ROWS; r++)
      send_tick(~settle_levels(r));
    for (int r = 0; r < NUM_ROWS; r++)
      send_tick(r < 4 ? ~settle_levels(r) : settle_levels(r));
    // Keep the traffic planner in step with where the keys now sit.
    for (int k = 0; k < NUM_KEYS; k++) begin
      plan_down[k] = (model_phase[k] == PH_DOWN || model_phase[k] == PH_WAIT_UP);
      plan_hold[k] = 0;
    end
  endtask

  task automatic test_reset_threshold_values();
    run_debounce_traffic(300, PRESS_THRESHOLD_RESET, RELEASE_THRESHOLD_RESET, 1'b0);
  endtask

  // Zero thresholds under full throughput with no idling on either side.
  task automatic test_back_to_back_ticks();
    run_debounce_traffic(150, '0, '0, 1'b1);
  endtask

  // The counter has to climb all the way to 31 before either event.
  task automatic test_max_thresholds();
    run_debounce_traffic(350, 5'd31, 5'd31, 1'b0);
  endtask

  task automatic test_asymmetric_thresholds();
    run_debounce_traffic(200, 5'd31, '0, 1'b0);
    run_debounce_traffic(200, '0, 5'd31, 1'b0);
  endtask

  task automatic test_random_thresholds();
    logic [CNT_W-1:0] press_thr;
    logic [CNT_W-1:0] release_thr;
    press_thr   = CNT_W'($urandom_range(0, 7));
    release_thr = CNT_W'($urandom_range(0, 7));
    run_debounce_traffic(200, press_thr, release_thr, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: the receiver stalls in random bursts, like the sender.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rx_gap = pick_gap();
      if (rx_gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= rx_gap - 1;
      end
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_scans.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: row %0d next %0d press %b release %b",
                   scanned_row, next_row, press_mask, release_mask);
      end else if (scanned_row  !== expected_scans[0].scanned_row ||
                   next_row     !== expected_scans[0].next_row ||
                   press_mask   !== expected_scans[0].press_mask ||
                   release_mask !== expected_scans[0].release_mask) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display({"mismatch: row exp %0d got %0d, next exp %0d got %0d, ",
                    "press exp %b got %b, release exp %b got %b"},
                   expected_scans[0].scanned_row, scanned_row,
                   expected_scans[0].next_row, next_row,
                   expected_scans[0].press_mask, press_mask,
                   expected_scans[0].release_mask, release_mask);
        void'(expected_scans.pop_front());
      end else begin
        void'(expected_scans.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    model_row         = '0;
    model_press_thr   = PRESS_THRESHOLD_RESET;
    model_release_thr = RELEASE_THRESHOLD_RESET;
    for (int k = 0; k < NUM_KEYS; k++) begin
      model_phase[k] = PH_UNKNOWN;
      model_count[k] = '0;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_settle_from_unknown();
    test_zero_thresholds();
    test_reset_threshold_values();
    test_back_to_back_ticks();
    test_max_thresholds();
    test_asymmetric_thresholds();
    test_random_thresholds();

    wait_until_idle();
    // Anything still owed at this point was never delivered.
    fail_count += expected_scans.size();

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
